FILE: src/cagrid_pkg.sv
// Shared constants, codes and types of the cellular automaton grid block.
package cagrid_pkg;

	// Grid geometry limits and derived storage widths.
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int GRID_CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int CELL_AW    = $clog2(GRID_CELLS);
	localparam int SIZE_W     = CELL_AW + 1;

	// Field widths of the channels and registers.
	localparam int FUNC_W    = 2;
	localparam int INDEX_W   = 12;
	localparam int GEN_W     = 16;
	localparam int DIM_W     = 7;
	localparam int RULE_W    = 2;
	localparam int MOD_CNT_W = $clog2(INDEX_W);

	// Configuration port geometry.
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_LSB   = 2;

	// Operation carried by an input word.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE  = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_STEP   = 2'd2,
		FUNC_INVERT = 2'd3
	} func_t;

	// Generation rule selected by the rule register.
	typedef enum logic [RULE_W-1:0] {
		RULE_LE4    = 2'd0,
		RULE_LE6    = 2'd1,
		RULE_CAVERN = 2'd2,
		RULE_GT5    = 2'd3
	} rule_t;

	// Register indexes on the configuration port.
	typedef enum logic [PADDR_W-REG_LSB-1:0] {
		REG_RULE_MODE   = 2'd0,
		REG_GRID_WIDTH  = 2'd1,
		REG_GRID_HEIGHT = 2'd2
	} reg_idx_t;

	// Register contents handed from the register file to the datapath.
	typedef struct packed {
		rule_t             rule_mode;
		logic [DIM_W-1:0]  grid_width;
		logic [DIM_W-1:0]  grid_height;
	} cfg_t;

endpackage

FILE: src/cagrid_req_if.sv
// Request channel carrying one operation word into the grid block.
interface cagrid_req_if import cagrid_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [INDEX_W-1:0] cell_index;
	logic               cell_value;

	modport source (output valid, output func, output cell_index, output cell_value,
		input ready);
	modport sink (input valid, input func, input cell_index, input cell_value,
		output ready);
endinterface

FILE: src/cagrid_rsp_if.sv
// Response channel carrying one result word out of the grid block.
interface cagrid_rsp_if import cagrid_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             read_value;
	logic [GEN_W-1:0] generations_done;

	modport source (output valid, output read_value, output generations_done,
		input ready);
	modport sink (input valid, input read_value, input generations_done,
		output ready);
endinterface

FILE: src/cagrid_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
module cagrid_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic          rdata_a,
	output logic          rdata_b
);

	logic mem [DEPTH];
	logic rd_a_q;
	logic rd_b_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports, registered.
	always_ff @(posedge clk) begin
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

FILE: src/cagrid_mod.sv
// Iterative remainder unit reducing a cell index modulo the grid size.
module cagrid_mod import cagrid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [INDEX_W-1:0] dividend,
	input  logic [SIZE_W-1:0]  divisor,
	output logic               done,
	output logic [CELL_AW-1:0] rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [INDEX_W-1:0]   dsh_q;
	logic [CELL_AW-1:0]   rem_q;
	logic [SIZE_W-1:0]    trial;
	logic                 ge;
	logic [CELL_AW-1:0]   rem_nxt;

	// One restoring step: bring in the next dividend bit and subtract if it fits.
	always_comb begin
		trial   = {rem_q, dsh_q[INDEX_W-1]};
		ge      = (trial >= divisor);
		rem_nxt = ge ? CELL_AW'(trial - divisor) : CELL_AW'(trial);
	end

	// Sequencing of the bit steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MOD_CNT_W'(INDEX_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and dividend shifter.
	always_ff @(posedge clk) begin
		if (start) begin
			dsh_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dsh_q <= {dsh_q[INDEX_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: src/cagrid_cfg.sv
// Configuration register file behind the APB-style port.
module cagrid_cfg import cagrid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	rule_t            rule_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	reg_idx_t         reg_idx;
	logic             wr_en;

	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:REG_LSB]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register writes in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q   <= RULE_GT5;
			width_q  <= DIM_W'(MAX_WIDTH);
			height_q <= DIM_W'(MAX_HEIGHT);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RULE_MODE:   rule_q   <= rule_t'(pwdata[RULE_W-1:0]);
				REG_GRID_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_GRID_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		unique case (reg_idx)
			REG_RULE_MODE:   prdata = PDATA_W'(rule_q);
			REG_GRID_WIDTH:  prdata = PDATA_W'(width_q);
			REG_GRID_HEIGHT: prdata = PDATA_W'(height_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg = '{rule_mode: rule_q, grid_width: width_q, grid_height: height_q};

endmodule

FILE: src/cellular_automaton_grid_step.sv
// Top level of the one-bit cellular automaton grid with Moore-neighbourhood step.
// The grid lives in two 4096 x 1 RAM banks used in ping-pong fashion; a bank
// select bit marks the one holding the current generation. Words arrive on the
// req channel (write cell, read cell, step, invert) and each gives exactly one
// word on rsp, carrying the read bit and the generation count after the word.
// Writes and reads first reduce the index modulo width*height in a bit-serial
// remainder unit. A step reads the current bank through three sliding windows
// (row above, own row, row below along the flattened index), its pace set by
// the two read ports of the bank; a copy of the unused tail into the new bank
// follows, and that bank then becomes current.
// An invert rewrites the used cells in place.
// One word is in work at a time; req.ready is high only while idle.
// After reset bank 0 is swept to zero with req.ready low; register writes are
// taken throughout. A finished result waits in an output register, so the next
// word is accepted while rsp is stalled.
module cellular_automaton_grid_step import cagrid_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	cagrid_req_if.sink          req,
	cagrid_rsp_if.source        rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_PREP  = 9'b000000100,
		ST_MOD   = 9'b000001000,
		ST_RDW   = 9'b000010000,
		ST_STEP  = 9'b000100000,
		ST_COPY  = 9'b001000000,
		ST_INV   = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	typedef struct packed {
		logic               en;
		logic [CELL_AW-1:0] addr;
		logic               data;
	} wr_t;

	// Clamp a dimension register to the range in use.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		begin
			if (v == '0) r = DIM_W'(1);
			else if (v > maxv) r = maxv;
			else r = v;
			return r;
		end
	endfunction

	// Advance a stream pointer, wrapping at the grid size.
	function automatic logic [CELL_AW-1:0] adv(input logic [CELL_AW-1:0] ptr,
		input logic [SIZE_W-1:0] sz);
		logic [CELL_AW-1:0] r;
		begin
			if ({1'b0, ptr} == sz - SIZE_W'(1)) r = '0;
			else r = ptr + 1'b1;
			return r;
		end
	endfunction

	// Live count of the eight neighbours.
	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] s;
		begin
			s = '0;
			for (int i = 0; i < 8; i++) s = s + 4'(v[i]);
			return s;
		end
	endfunction

	// Next state of one cell under the selected rule.
	function automatic logic next_cell(input rule_t rule, input logic cur_bit,
		input logic [3:0] cnt);
		logic r;
		begin
			case (rule)
				RULE_LE4: r = (cnt <= 4'd4);
				RULE_LE6: r = (cnt <= 4'd6);
				RULE_CAVERN: begin
					if (cnt > 4'd4) r = 1'b1;
					else if (cnt < 4'd4) r = 1'b0;
					else r = cur_bit;
				end
				default: r = (cnt > 4'd5);
			endcase
			return r;
		end
	endfunction

	cfg_t               cfg;
	state_t             state_q, state_d;
	logic               cur_q;
	logic [GEN_W-1:0]   gen_q;
	logic [SIZE_W-1:0]  swp_q;
	logic               swp_v_s1;
	logic [CELL_AW-1:0] swp_addr_s1;
	logic               ph_q;
	logic [1:0]         prime_q;
	logic               bpend_q;
	logic               out_v_q;
	logic               out_rd_q;
	logic [GEN_W-1:0]   out_gen_q;
	func_t              func_q;
	logic [INDEX_W-1:0] idx_q;
	logic               val_q;
	logic [DIM_W-1:0]   w_q, h_q;
	logic [SIZE_W-1:0]  size_q;
	logic [CELL_AW-1:0] tq_q, mq_q, bq_q, wp_q;
	logic [2:0]         tw_q, mw_q, bw_q;
	logic               res_rd_q;

	logic               st_clear, st_idle, st_prep, st_mod, st_rdw;
	logic               st_step, st_copy, st_inv, st_fin;
	logic               accept, out_free, swp_issue, sweep_idle;
	logic               eval, step_last, new_bit, mod_start, mod_done;
	logic [CELL_AW-1:0] mod_rem;
	logic [3:0]         live_cnt;
	logic [DIM_W-1:0]   w_eff, h_eff;
	logic [SIZE_W-1:0]  wp1, r_off;
	logic [CELL_AW-1:0] tq_init;
	logic [CELL_AW-1:0] raddr_a, raddr_b;
	logic               rd_a, rd_b, b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b;
	wr_t                wr_cur, wr_oth, wr_b0, wr_b1;

	// Register file.
	cagrid_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Index reduction unit.
	assign mod_start = st_prep && (func_q == FUNC_WRITE || func_q == FUNC_READ);

	cagrid_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (idx_q),
		.divisor  (size_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// State decodes and handshake.
	assign st_clear = (state_q == ST_CLEAR);
	assign st_idle  = (state_q == ST_IDLE);
	assign st_prep  = (state_q == ST_PREP);
	assign st_mod   = (state_q == ST_MOD);
	assign st_rdw   = (state_q == ST_RDW);
	assign st_step  = (state_q == ST_STEP);
	assign st_copy  = (state_q == ST_COPY);
	assign st_inv   = (state_q == ST_INV);
	assign st_fin   = (state_q == ST_FIN);

	assign req.ready = st_idle;
	assign accept    = req.valid && st_idle;
	assign out_free  = !out_v_q || rsp.ready;

	assign rsp.valid            = out_v_q;
	assign rsp.read_value       = out_rd_q;
	assign rsp.generations_done = out_gen_q;

	// Dimensions in use at acceptance.
	assign w_eff = eff_dim(cfg.grid_width, DIM_W'(MAX_WIDTH));
	assign h_eff = eff_dim(cfg.grid_height, DIM_W'(MAX_HEIGHT));

	// Start of the upper-row stream: (-w-1) reduced modulo the grid size.
	always_comb begin
		wp1 = SIZE_W'(w_q) + SIZE_W'(1);
		if (h_q != DIM_W'(1)) r_off = (wp1 == size_q) ? '0 : wp1;
		else r_off = (w_q == DIM_W'(1)) ? '0 : SIZE_W'(1);
		tq_init = (r_off == '0) ? '0 : CELL_AW'(size_q - r_off);
	end

	// Sweep issue for invert and tail copy.
	assign swp_issue  = (st_copy && !swp_q[CELL_AW]) || (st_inv && (swp_q < size_q));
	assign sweep_idle = !swp_issue && !swp_v_s1;

	// Cell evaluation from the three windows.
	assign eval      = st_step && ph_q && (prime_q == 2'd3);
	assign step_last = eval && ({1'b0, wp_q} == size_q - SIZE_W'(1));
	assign live_cnt  = pop8({tw_q, mw_q[2], mw_q[0], bw_q});
	assign new_bit   = next_cell(cfg.rule_mode, mw_q[1], live_cnt);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (swp_q == SIZE_W'(GRID_CELLS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (req.valid) state_d = ST_PREP;
			ST_PREP: begin
				unique case (func_q) inside
					FUNC_WRITE, FUNC_READ: state_d = ST_MOD;
					FUNC_STEP:             state_d = ST_STEP;
					default:               state_d = ST_INV;
				endcase
			end
			ST_MOD:   if (mod_done) state_d = (func_q == FUNC_READ) ? ST_RDW : ST_FIN;
			ST_RDW:   state_d = ST_FIN;
			ST_STEP:  if (step_last) state_d = ST_COPY;
			ST_COPY:  if (sweep_idle) state_d = ST_FIN;
			ST_INV:   if (sweep_idle) state_d = ST_FIN;
			ST_FIN:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			cur_q    <= 1'b0;
			gen_q    <= '0;
			swp_q    <= '0;
			swp_v_s1 <= 1'b0;
			ph_q     <= 1'b0;
			prime_q  <= '0;
			bpend_q  <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			swp_v_s1 <= swp_issue;
			bpend_q  <= st_step && ph_q;
			ph_q     <= st_step ? !ph_q : 1'b0;
			if (st_clear || swp_issue) begin
				swp_q <= swp_q + 1'b1;
			end else if (st_prep) begin
				swp_q <= (func_q == FUNC_STEP) ? size_q : '0;
			end
			if (st_prep) begin
				prime_q <= '0;
			end else if (st_step && ph_q && prime_q != 2'd3) begin
				prime_q <= prime_q + 1'b1;
			end
			if (st_copy && sweep_idle) begin
				cur_q <= !cur_q;
				gen_q <= gen_q + 1'b1;
			end
			if (st_fin && out_free) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(req.func);
			idx_q  <= req.cell_index;
			val_q  <= req.cell_value;
			w_q    <= w_eff;
			h_q    <= h_eff;
			size_q <= SIZE_W'(w_eff) * SIZE_W'(h_eff);
		end
		if (st_prep) begin
			tq_q     <= tq_init;
			mq_q     <= CELL_AW'(size_q - SIZE_W'(1));
			bq_q     <= CELL_AW'(w_q - DIM_W'(1));
			wp_q     <= '0;
			res_rd_q <= 1'b0;
		end
		if (st_step) begin
			if (!ph_q) begin
				tq_q <= adv(tq_q, size_q);
				mq_q <= adv(mq_q, size_q);
				if (bpend_q) bw_q <= {bw_q[1:0], rd_a};
			end else begin
				bq_q <= adv(bq_q, size_q);
				tw_q <= {tw_q[1:0], rd_a};
				mw_q <= {mw_q[1:0], rd_b};
			end
			if (eval) wp_q <= wp_q + 1'b1;
		end
		swp_addr_s1 <= swp_q[CELL_AW-1:0];
		if (st_rdw) res_rd_q <= rd_a;
		if (st_fin && out_free) begin
			out_rd_q  <= res_rd_q;
			out_gen_q <= gen_q;
		end
	end

	// Read addresses, shared by both banks.
	always_comb begin
		if (st_step) raddr_a = ph_q ? bq_q : tq_q;
		else if (st_mod) raddr_a = mod_rem;
		else raddr_a = swp_q[CELL_AW-1:0];
		raddr_b = mq_q;
	end

	// Writes into the current bank and into the next-generation bank.
	always_comb begin
		wr_cur = '{en: 1'b0, addr: swp_q[CELL_AW-1:0], data: 1'b0};
		wr_oth = '{en: 1'b0, addr: swp_addr_s1, data: rd_a};
		if (st_clear) begin
			wr_cur.en = 1'b1;
		end else if (st_mod && mod_done && func_q == FUNC_WRITE) begin
			wr_cur = '{en: 1'b1, addr: mod_rem, data: val_q};
		end else if (st_inv && swp_v_s1) begin
			wr_cur = '{en: 1'b1, addr: swp_addr_s1, data: !rd_a};
		end
		if (eval) begin
			wr_oth = '{en: 1'b1, addr: wp_q, data: new_bit};
		end else if (st_copy && swp_v_s1) begin
			wr_oth.en = 1'b1;
		end
	end

	assign wr_b0 = cur_q ? wr_oth : wr_cur;
	assign wr_b1 = cur_q ? wr_cur : wr_oth;
	assign rd_a  = cur_q ? b1_rd_a : b0_rd_a;
	assign rd_b  = cur_q ? b1_rd_b : b0_rd_b;

	// Grid storage banks.
	cagrid_ram #(.DEPTH(GRID_CELLS)) u_bank0 (
		.clk     (clk),
		.we      (wr_b0.en),
		.waddr   (wr_b0.addr),
		.wdata   (wr_b0.data),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (b0_rd_a),
		.rdata_b (b0_rd_b)
	);

	cagrid_ram #(.DEPTH(GRID_CELLS)) u_bank1 (
		.clk     (clk),
		.we      (wr_b1.en),
		.waddr   (wr_b1.addr),
		.wdata   (wr_b1.data),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (b1_rd_a),
		.rdata_b (b1_rd_b)
	);

	// The step never writes a cell beyond the grid in use.
	a_eval_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		eval |-> ({1'b0, wp_q} < size_q))
		else $error("step write beyond grid size");

	// The reduced index always lies inside the grid.
	a_rem_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> ({1'b0, mod_rem} < size_q))
		else $error("index remainder not below grid size");

	// The banks swap only at the end of the tail copy.
	a_bank_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q != $past(cur_q)) |-> ($past(state_q) == ST_COPY))
		else $error("bank select changed outside step completion");

	// The generation count moves together with the bank swap.
	a_gen_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(gen_q != $past(gen_q)) |-> (cur_q != $past(cur_q)))
		else $error("generation count changed without a bank swap");

	// A new result word only comes from the finishing state.
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_FIN))
		else $error("result word raised outside finishing state");

endmodule
